### sv/ppb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Periodic phase basis package
// Shared constants, register and mode codes, and the rotation angle table.
// ----------------------------------------------------------------------------
package ppb_pkg;

    localparam int ROTATION_STAGES_DEF = 24;
    localparam int SAMPLE_WIDTH_DEF    = 32;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;
    localparam int RESULT_W    = 32;
    localparam int PHASE_W     = 32;
    localparam int PERIOD_W    = 32;
    localparam int CORDIC_W    = 32;
    localparam int MAG_W       = 31;
    localparam int TAN_FRAC    = 24;
    localparam int EXT_W       = 48;

    localparam logic [29:0] TURN_PER_RAD_Q32 = 30'd683565276;
    localparam logic [29:0] DEG_PER_RAD_Q24  = 30'd961263669;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 32'sd652032874;
    localparam logic [PERIOD_W-1:0] DAY_PERIOD  = 32'd1572864;
    localparam logic [PERIOD_W-1:0] YEAR_PERIOD = 32'd23920640;

    localparam logic [2:0] MODE_SIN     = 3'd0;
    localparam logic [2:0] MODE_COS     = 3'd1;
    localparam logic [2:0] MODE_DAY     = 3'd2;
    localparam logic [2:0] MODE_YEAR    = 3'd3;
    localparam logic [2:0] MODE_TAN     = 3'd4;
    localparam logic [2:0] MODE_SINCOS  = 3'd5;
    localparam logic [2:0] MODE_RAW_COS = 3'd6;

    localparam logic [CFG_INDEX_W-1:0] REG_MODE   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_OFFSET = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SCALE  = 8'd3;

    typedef enum logic [1:0] {
        KIND_SIN    = 2'd0,
        KIND_COS    = 2'd1,
        KIND_TAN    = 2'd2,
        KIND_SINCOS = 2'd3
    } t_kind;

    function automatic logic [31:0] atan_turns(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            24: v = 32'd41;
            25: v = 32'd20;
            26: v = 32'd10;
            27: v = 32'd5;
            28: v = 32'd3;
            29: v = 32'd1;
            30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

### sv/ppb_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Restoring divider cell
// One quotient bit per cell: shift the next dividend bit into the remainder,
// subtract the divisor when it fits, and shift the quotient bit in.
// ----------------------------------------------------------------------------
module ppb_div_cell #(
    parameter int NUM_W  = 32,
    parameter int DIV_W  = 32,
    parameter int SIDE_W = 1
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_en,
    input  wire              i_valid,
    input  wire [NUM_W-1:0]  i_num,
    input  wire [DIV_W-1:0]  i_rem,
    input  wire [DIV_W-1:0]  i_div,
    input  wire [SIDE_W-1:0] i_side,
    output logic             o_valid,
    output logic [NUM_W-1:0] o_num,
    output logic [DIV_W-1:0] o_rem,
    output logic [DIV_W-1:0] o_div,
    output logic [SIDE_W-1:0] o_side
);

    logic [DIV_W:0]   w_trial;
    logic [DIV_W:0]   w_diff;
    logic             w_take;
    logic [NUM_W-1:0] n_num;
    logic [DIV_W-1:0] n_rem;

    logic             r_valid;
    logic [NUM_W-1:0] r_num;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_div;
    logic [SIDE_W-1:0] r_side;

    assign w_trial = {i_rem, i_num[NUM_W-1]};
    assign w_diff  = w_trial - {1'b0, i_div};
    assign w_take  = (w_trial >= {1'b0, i_div});
    assign n_rem   = w_take ? w_diff[DIV_W-1:0] : w_trial[DIV_W-1:0];
    assign n_num   = {i_num[NUM_W-2:0], w_take};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num  <= n_num;
            r_rem  <= n_rem;
            r_div  <= i_div;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_num   = r_num;
    assign o_rem   = r_rem;
    assign o_div   = r_div;
    assign o_side  = r_side;

endmodule
`default_nettype wire

### sv/ppb_cordic_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rotation cell
// One micro-rotation of the angle reduction, with a fixed shift and angle.
// ----------------------------------------------------------------------------
module ppb_cordic_cell #(
    parameter int SHIFT  = 0,
    parameter int SIDE_W = 1
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_en,
    input  wire                                  i_valid,
    input  wire signed [ppb_pkg::CORDIC_W-1:0]   i_x,
    input  wire signed [ppb_pkg::CORDIC_W-1:0]   i_y,
    input  wire signed [ppb_pkg::CORDIC_W-1:0]   i_z,
    input  wire [SIDE_W-1:0]                     i_side,
    output logic                                 o_valid,
    output logic signed [ppb_pkg::CORDIC_W-1:0]  o_x,
    output logic signed [ppb_pkg::CORDIC_W-1:0]  o_y,
    output logic signed [ppb_pkg::CORDIC_W-1:0]  o_z,
    output logic [SIDE_W-1:0]                    o_side
);

    localparam logic signed [ppb_pkg::CORDIC_W-1:0] ATAN =
        signed'(ppb_pkg::atan_turns(SHIFT));

    logic signed [ppb_pkg::CORDIC_W-1:0] w_dx;
    logic signed [ppb_pkg::CORDIC_W-1:0] w_dy;
    logic signed [ppb_pkg::CORDIC_W-1:0] n_x;
    logic signed [ppb_pkg::CORDIC_W-1:0] n_y;
    logic signed [ppb_pkg::CORDIC_W-1:0] n_z;

    logic                                r_valid;
    logic signed [ppb_pkg::CORDIC_W-1:0] r_x;
    logic signed [ppb_pkg::CORDIC_W-1:0] r_y;
    logic signed [ppb_pkg::CORDIC_W-1:0] r_z;
    logic [SIDE_W-1:0]                   r_side;

    assign w_dx = i_y >>> SHIFT;
    assign w_dy = i_x >>> SHIFT;

    always_comb begin
        if (!i_z[ppb_pkg::CORDIC_W-1]) begin
            n_x = i_x - w_dx;
            n_y = i_y + w_dy;
            n_z = i_z - ATAN;
        end else begin
            n_x = i_x + w_dx;
            n_y = i_y - w_dy;
            n_z = i_z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_side  = r_side;

endmodule
`default_nettype wire

### sv/periodic_phase_basis_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Periodic phase basis
// Throughput: one sample per cycle; the phase divider, rotation and tangent
// divider are chains of one-step cells, so every stage takes a new item.
// The whole pipeline holds while the output register is full and not taken.
// Reset (synchronous, active low) clears all valid bits and loads the
// register defaults: sine mode, period 24.0, zero offset, no degree scaling.
// ----------------------------------------------------------------------------
module periodic_phase_basis_top #(
    parameter int ROTATION_STAGES = ppb_pkg::ROTATION_STAGES_DEF,
    parameter int SAMPLE_WIDTH    = ppb_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_s_tvalid,
    output logic                                  o_s_tready,
    // sample_value
    input  wire [((SAMPLE_WIDTH+7)/8)*8-1:0]      i_s_tdata,
    output logic                                  o_m_tvalid,
    input  wire                                   i_m_tready,
    // first_result [31:0], second_result [63:32]
    output logic [2*ppb_pkg::RESULT_W-1:0]        o_m_tdata,
    // saturated
    output logic                                  o_m_tuser,
    input  wire                                   i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire [ppb_pkg::CFG_INDEX_W-1:0]        i_cfg_index,
    input  wire [ppb_pkg::CFG_DATA_W-1:0]         i_cfg_data
);

    localparam int PD_N   = SAMPLE_WIDTH + ppb_pkg::PHASE_W;
    localparam int PD_S   = ppb_pkg::PHASE_W + 1;
    localparam int TD_N   = ppb_pkg::MAG_W + ppb_pkg::TAN_FRAC;
    localparam int TD_S   = 2 * ppb_pkg::RESULT_W + 4;
    localparam int CR_S   = 3;
    localparam int RW     = ppb_pkg::RESULT_W;
    localparam int CW     = ppb_pkg::CORDIC_W;
    localparam logic [RW-1:0] POS_MAX = {1'b0, {(RW-1){1'b1}}};
    localparam logic [RW-1:0] NEG_MAX = {1'b1, {(RW-1){1'b0}}};

    function automatic logic [RW:0] deg_round(input logic signed [62:0] p);
        logic signed [62:0] t;
        t = (p + 63'sd8388608) >>> 24;
        if (t > 63'sd2147483647) begin
            deg_round = {1'b1, POS_MAX};
        end else if (t < -63'sd2147483648) begin
            deg_round = {1'b1, NEG_MAX};
        end else begin
            deg_round = {1'b0, t[RW-1:0]};
        end
    endfunction

    // configuration
    logic [2:0]                         r_mode;
    logic [ppb_pkg::PERIOD_W-1:0]       r_period;
    logic signed [ppb_pkg::CFG_DATA_W-1:0] r_offset;
    logic                               r_scale;
    logic signed [62:0]                 r_off_prod;
    logic [ppb_pkg::PHASE_W-1:0]        w_off_turns;

    logic                               w_raw;
    ppb_pkg::t_kind                     w_kind;
    logic [ppb_pkg::PERIOD_W-1:0]       w_eff_per;
    logic                               w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= ppb_pkg::MODE_SIN;
            r_period <= ppb_pkg::DAY_PERIOD;
            r_offset <= '0;
            r_scale  <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ppb_pkg::REG_MODE:   r_mode   <= i_cfg_data[2:0];
                ppb_pkg::REG_PERIOD: r_period <= i_cfg_data;
                ppb_pkg::REG_OFFSET: r_offset <= signed'(i_cfg_data);
                ppb_pkg::REG_SCALE:  r_scale  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        r_off_prod <= r_offset * signed'({1'b0, ppb_pkg::TURN_PER_RAD_Q32});
    end

    assign w_off_turns = r_off_prod[59:28];

    always_comb begin
        w_raw     = 1'b0;
        w_kind    = ppb_pkg::KIND_COS;
        w_eff_per = r_period;
        case (r_mode)
            ppb_pkg::MODE_SIN:    w_kind = ppb_pkg::KIND_SIN;
            ppb_pkg::MODE_COS:    w_kind = ppb_pkg::KIND_COS;
            ppb_pkg::MODE_DAY:    w_eff_per = ppb_pkg::DAY_PERIOD;
            ppb_pkg::MODE_YEAR:   w_eff_per = ppb_pkg::YEAR_PERIOD;
            ppb_pkg::MODE_TAN: begin
                w_kind = ppb_pkg::KIND_TAN;
                w_raw  = 1'b1;
            end
            ppb_pkg::MODE_SINCOS: w_kind = ppb_pkg::KIND_SINCOS;
            default:              w_raw  = 1'b1;
        endcase
    end

    // hold every stage while the output register waits
    assign w_adv      = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_adv;

    // stage 1: magnitude and raw-angle partial products
    logic signed [SAMPLE_WIDTH-1:0]     w_smp;
    logic signed [ppb_pkg::EXT_W-1:0]   w_s48;
    logic [SAMPLE_WIDTH-1:0]            w_mag;
    logic [53:0]                        w_pl;
    logic [53:0]                        w_ph;

    logic                               r_s1_valid;
    logic [SAMPLE_WIDTH-1:0]            r_s1_mag;
    logic                               r_s1_neg;
    logic [47:0]                        r_s1_pl;
    logic [23:0]                        r_s1_ph;

    assign w_smp = signed'(i_s_tdata[SAMPLE_WIDTH-1:0]);
    assign w_s48 = ppb_pkg::EXT_W'(w_smp);
    assign w_mag = w_smp[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-w_smp) : SAMPLE_WIDTH'(w_smp);
    assign w_pl  = w_s48[23:0] * ppb_pkg::TURN_PER_RAD_Q32;
    assign w_ph  = w_s48[47:24] * ppb_pkg::TURN_PER_RAD_Q32;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_mag <= w_mag;
            r_s1_neg <= w_smp[SAMPLE_WIDTH-1];
            r_s1_pl  <= w_pl[47:0];
            r_s1_ph  <= w_ph[23:0];
        end
    end

    // stage 2: raw angle in turns
    logic [47:0]                        w_raw_sum;
    logic                               r_s2_valid;
    logic [SAMPLE_WIDTH-1:0]            r_s2_mag;
    logic                               r_s2_neg;
    logic [ppb_pkg::PHASE_W-1:0]        r_s2_raw;

    assign w_raw_sum = {r_s1_ph, 24'd0} + r_s1_pl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_mag <= r_s1_mag;
            r_s2_neg <= r_s1_neg;
            r_s2_raw <= w_raw_sum[47:16];
        end
    end

    // phase divider: floor(|sample| * 2^32 / period), one bit per cell
    logic                               w_pd_valid [0:PD_N];
    logic [PD_N-1:0]                    w_pd_num   [0:PD_N];
    logic [ppb_pkg::PERIOD_W-1:0]       w_pd_rem   [0:PD_N];
    logic [ppb_pkg::PERIOD_W-1:0]       w_pd_div   [0:PD_N];
    logic [PD_S-1:0]                    w_pd_side  [0:PD_N];

    assign w_pd_valid[0] = r_s2_valid;
    assign w_pd_num[0]   = {r_s2_mag, {ppb_pkg::PHASE_W{1'b0}}};
    assign w_pd_rem[0]   = '0;
    assign w_pd_div[0]   = w_eff_per;
    assign w_pd_side[0]  = {r_s2_raw, r_s2_neg};

    for (genvar g = 0; g < PD_N; g++) begin : g_pd
        ppb_div_cell #(
            .NUM_W  (PD_N),
            .DIV_W  (ppb_pkg::PERIOD_W),
            .SIDE_W (PD_S)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_valid (w_pd_valid[g]),
            .i_num   (w_pd_num[g]),
            .i_rem   (w_pd_rem[g]),
            .i_div   (w_pd_div[g]),
            .i_side  (w_pd_side[g]),
            .o_valid (w_pd_valid[g+1]),
            .o_num   (w_pd_num[g+1]),
            .o_rem   (w_pd_rem[g+1]),
            .o_div   (w_pd_div[g+1]),
            .o_side  (w_pd_side[g+1])
        );
    end

    // phase stage
    logic [ppb_pkg::PHASE_W-1:0]        w_frac;
    logic [ppb_pkg::PHASE_W-1:0]        w_frac_adj;
    logic                               w_pd_neg;
    logic [ppb_pkg::PHASE_W-1:0]        w_pd_raw;
    logic                               r_p_valid;
    logic [ppb_pkg::PHASE_W-1:0]        r_p_phase;
    logic                               r_p_bad;

    assign w_frac   = w_pd_num[PD_N][ppb_pkg::PHASE_W-1:0];
    assign w_pd_neg = w_pd_side[PD_N][0];
    assign w_pd_raw = w_pd_side[PD_N][PD_S-1:1];

    always_comb begin
        if (!w_pd_neg) begin
            w_frac_adj = w_frac;
        end else if (w_pd_rem[PD_N] == '0) begin
            w_frac_adj = -w_frac;
        end else begin
            w_frac_adj = ~w_frac;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (w_adv) begin
            r_p_valid <= w_pd_valid[PD_N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p_phase <= w_raw ? w_pd_raw : w_frac_adj + w_off_turns;
            r_p_bad   <= !w_raw && (w_eff_per == '0);
        end
    end

    // rotation chain
    logic                               w_cr_valid [0:ROTATION_STAGES];
    logic signed [CW-1:0]               w_cr_x     [0:ROTATION_STAGES];
    logic signed [CW-1:0]               w_cr_y     [0:ROTATION_STAGES];
    logic signed [CW-1:0]               w_cr_z     [0:ROTATION_STAGES];
    logic [CR_S-1:0]                    w_cr_side  [0:ROTATION_STAGES];

    assign w_cr_valid[0] = r_p_valid;
    assign w_cr_x[0]     = ppb_pkg::CORDIC_GAIN_Q30;
    assign w_cr_y[0]     = '0;
    assign w_cr_z[0]     = signed'({2'b00, r_p_phase[ppb_pkg::PHASE_W-3:0]});
    assign w_cr_side[0]  = {r_p_phase[ppb_pkg::PHASE_W-1 -: 2], r_p_bad};

    for (genvar g = 0; g < ROTATION_STAGES; g++) begin : g_cr
        ppb_cordic_cell #(
            .SHIFT  (g),
            .SIDE_W (CR_S)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_valid (w_cr_valid[g]),
            .i_x     (w_cr_x[g]),
            .i_y     (w_cr_y[g]),
            .i_z     (w_cr_z[g]),
            .i_side  (w_cr_side[g]),
            .o_valid (w_cr_valid[g+1]),
            .o_x     (w_cr_x[g+1]),
            .o_y     (w_cr_y[g+1]),
            .o_z     (w_cr_z[g+1]),
            .o_side  (w_cr_side[g+1])
        );
    end

    // quadrant unfold, rounding and tangent operands
    logic signed [CW-1:0]               w_x;
    logic signed [CW-1:0]               w_y;
    logic signed [CW-1:0]               w_c;
    logic signed [CW-1:0]               w_s;
    logic signed [CW:0]                 w_s_rnd;
    logic signed [CW:0]                 w_c_rnd;
    logic signed [CW:0]                 w_s_sh;
    logic signed [CW:0]                 w_c_sh;
    logic [ppb_pkg::MAG_W-1:0]          w_ms;
    logic [ppb_pkg::MAG_W-1:0]          w_mc;

    logic                               r_t_valid;
    logic [ppb_pkg::MAG_W-1:0]          r_t_ms;
    logic [ppb_pkg::MAG_W-1:0]          r_t_mc;
    logic [TD_S-1:0]                    r_t_side;

    assign w_x = w_cr_x[ROTATION_STAGES];
    assign w_y = w_cr_y[ROTATION_STAGES];

    always_comb begin
        case (w_cr_side[ROTATION_STAGES][2:1])
            2'd0: begin
                w_c = w_x;
                w_s = w_y;
            end
            2'd1: begin
                w_c = -w_y;
                w_s = w_x;
            end
            2'd2: begin
                w_c = -w_x;
                w_s = -w_y;
            end
            default: begin
                w_c = w_y;
                w_s = -w_x;
            end
        endcase
    end

    assign w_s_rnd = (CW+1)'(w_s) + 33'sd32;
    assign w_c_rnd = (CW+1)'(w_c) + 33'sd32;
    assign w_s_sh  = w_s_rnd >>> 6;
    assign w_c_sh  = w_c_rnd >>> 6;
    assign w_ms    = w_s[CW-1] ? ppb_pkg::MAG_W'(-w_s) : w_s[ppb_pkg::MAG_W-1:0];
    assign w_mc    = w_c[CW-1] ? ppb_pkg::MAG_W'(-w_c) : w_c[ppb_pkg::MAG_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_valid <= 1'b0;
        end else if (w_adv) begin
            r_t_valid <= w_cr_valid[ROTATION_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_t_ms   <= w_ms;
            r_t_mc   <= w_mc;
            r_t_side <= {w_s_sh[RW-1:0], w_c_sh[RW-1:0],
                         w_s[CW-1] ^ w_c[CW-1], w_s[CW-1], (w_mc == '0),
                         w_cr_side[ROTATION_STAGES][0]};
        end
    end

    // tangent divider: |sin| * 2^24 / |cos|
    logic                               w_td_valid [0:TD_N];
    logic [TD_N-1:0]                    w_td_num   [0:TD_N];
    logic [ppb_pkg::MAG_W-1:0]          w_td_rem   [0:TD_N];
    logic [ppb_pkg::MAG_W-1:0]          w_td_div   [0:TD_N];
    logic [TD_S-1:0]                    w_td_side  [0:TD_N];

    assign w_td_valid[0] = r_t_valid;
    assign w_td_num[0]   = {r_t_ms, {ppb_pkg::TAN_FRAC{1'b0}}};
    assign w_td_rem[0]   = '0;
    assign w_td_div[0]   = r_t_mc;
    assign w_td_side[0]  = r_t_side;

    for (genvar g = 0; g < TD_N; g++) begin : g_td
        ppb_div_cell #(
            .NUM_W  (TD_N),
            .DIV_W  (ppb_pkg::MAG_W),
            .SIDE_W (TD_S)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_valid (w_td_valid[g]),
            .i_num   (w_td_num[g]),
            .i_rem   (w_td_rem[g]),
            .i_div   (w_td_div[g]),
            .i_side  (w_td_side[g]),
            .o_valid (w_td_valid[g+1]),
            .o_num   (w_td_num[g+1]),
            .o_rem   (w_td_rem[g+1]),
            .o_div   (w_td_div[g+1]),
            .o_side  (w_td_side[g+1])
        );
    end

    // result select
    logic [TD_N-1:0]                    w_q;
    logic [RW-1:0]                      w_q24s;
    logic [RW-1:0]                      w_q24c;
    logic                               w_tneg;
    logic                               w_sneg;
    logic                               w_mczero;
    logic                               w_tbad;
    logic [RW-1:0]                      w_lim;
    logic                               w_q_big;
    logic [RW-1:0]                      w_qc;
    logic [RW-1:0]                      w_tan;
    logic [RW-1:0]                      w_r1;
    logic [RW-1:0]                      w_r2;
    logic                               w_rsat;

    logic                               r_r_valid;
    logic signed [RW-1:0]               r_r_r1;
    logic signed [RW-1:0]               r_r_r2;
    logic                               r_r_sat;
    logic                               r_r_bad;

    assign w_q      = w_td_num[TD_N];
    assign w_q24s   = w_td_side[TD_N][TD_S-1 -: RW];
    assign w_q24c   = w_td_side[TD_N][TD_S-RW-1 -: RW];
    assign w_tneg   = w_td_side[TD_N][3];
    assign w_sneg   = w_td_side[TD_N][2];
    assign w_mczero = w_td_side[TD_N][1];
    assign w_tbad   = w_td_side[TD_N][0];
    assign w_lim    = w_tneg ? NEG_MAX : POS_MAX;
    assign w_q_big  = (|w_q[TD_N-1:RW]) || (w_q[RW-1:0] > w_lim);
    assign w_qc     = w_q_big ? w_lim : w_q[RW-1:0];

    always_comb begin
        if (w_mczero) begin
            w_tan = w_sneg ? NEG_MAX : POS_MAX;
        end else if (w_tneg) begin
            w_tan = -w_qc;
        end else begin
            w_tan = w_qc;
        end
    end

    always_comb begin
        w_r2   = '0;
        w_rsat = 1'b0;
        case (w_kind)
            ppb_pkg::KIND_SIN: w_r1 = w_q24s;
            ppb_pkg::KIND_COS: w_r1 = w_q24c;
            ppb_pkg::KIND_TAN: begin
                w_r1   = w_tan;
                w_rsat = w_mczero || w_q_big;
            end
            ppb_pkg::KIND_SINCOS: begin
                w_r1 = w_q24s;
                w_r2 = w_q24c;
            end
            default: w_r1 = w_q24c;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_valid <= 1'b0;
        end else if (w_adv) begin
            r_r_valid <= w_td_valid[TD_N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_r_r1  <= signed'(w_r1);
            r_r_r2  <= signed'(w_r2);
            r_r_sat <= w_rsat;
            r_r_bad <= w_tbad;
        end
    end

    // degree scaling products
    logic                               r_m_valid;
    logic signed [62:0]                 r_m_p1;
    logic signed [62:0]                 r_m_p2;
    logic [RW-1:0]                      r_m_r1;
    logic [RW-1:0]                      r_m_r2;
    logic                               r_m_sat;
    logic                               r_m_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_adv) begin
            r_m_valid <= r_r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m_p1  <= r_r_r1 * signed'({1'b0, ppb_pkg::DEG_PER_RAD_Q24});
            r_m_p2  <= r_r_r2 * signed'({1'b0, ppb_pkg::DEG_PER_RAD_Q24});
            r_m_r1  <= r_r_r1;
            r_m_r2  <= r_r_r2;
            r_m_sat <= r_r_sat;
            r_m_bad <= r_r_bad;
        end
    end

    // output register
    logic [RW:0]                        w_d1;
    logic [RW:0]                        w_d2;
    logic [RW-1:0]                      n_first;
    logic [RW-1:0]                      n_second;
    logic                               n_sat;

    assign w_d1 = deg_round(r_m_p1);
    assign w_d2 = deg_round(r_m_p2);

    always_comb begin
        if (r_m_bad) begin
            n_first  = '0;
            n_second = '0;
            n_sat    = 1'b1;
        end else if (r_scale) begin
            n_first  = w_d1[RW-1:0];
            n_second = w_d2[RW-1:0];
            n_sat    = r_m_sat || w_d1[RW] || w_d2[RW];
        end else begin
            n_first  = r_m_r1;
            n_second = r_m_r2;
            n_sat    = r_m_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_m_tvalid <= 1'b0;
        end else if (w_adv) begin
            o_m_tvalid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_m_tdata <= {n_second, n_first};
            o_m_tuser <= n_sat;
        end
    end

    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |-> !o_s_tready)
        else $error("input taken while output stalled");

    a_ready_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (o_m_tvalid && !i_m_tready))
        else $error("input held without output stall");

    a_transfer_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> r_s1_valid)
        else $error("accepted transfer lost at first stage");

endmodule
`default_nettype wire

### sim/periodic_phase_basis_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic phase basis testbench
// Streams samples through the block under several register settings and
// random stalls on both sides. A software rotation model predicts each result,
// and every result that leaves the block is compared with it.
// ----------------------------------------------------------------------------
module periodic_phase_basis_top_tb;

    localparam int  STAGES     = 24;
    localparam int  LATENCY    = 150;
    localparam int  CYCLE_CAP  = 600000;
    localparam int  PHASES     = 16;
    localparam int  PER_PHASE  = 88;
    localparam int  HOLD_AFTER = 300;
    localparam longint unsigned TURNS_PER_RAD = 64'd683565276;
    localparam longint DEG_PER_RAD = 64'sd961263669;
    localparam longint ROT_GAIN    = 64'sd652032874;
    localparam longint ARC_TURNS [0:31] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10679838,
        5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
        10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0
    };

    typedef struct {
        logic [31:0] first_res;
        logic [31:0] second_res;
        logic        sat;
    } t_basis;

    class t_basis_scoreboard;
        logic [2:0]  mode;
        logic [31:0] period;
        logic [31:0] offset;
        logic        deg;
        t_basis      pending[$];
        int          mismatches;

        function new();
            mode = ppb_pkg::MODE_SIN;
            period = ppb_pkg::DAY_PERIOD;
            offset = '0;
            deg = 1'b0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [7:0] idx, logic [31:0] val);
            case (idx)
                ppb_pkg::REG_MODE:   mode = val[2:0];
                ppb_pkg::REG_PERIOD: period = val;
                ppb_pkg::REG_OFFSET: offset = val;
                ppb_pkg::REG_SCALE:  deg = val[0];
                default: ;
            endcase
        endfunction

        function longint clip(longint v, inout logic sat);
            if (v > 64'sd2147483647) begin
                sat = 1'b1;
                return 64'sd2147483647;
            end
            if (v < -64'sd2147483648) begin
                sat = 1'b1;
                return -64'sd2147483648;
            end
            return v;
        endfunction

        function longint q24(longint v);
            return (v + 32) >>> 6;
        endfunction

        function longint degrees(longint v, inout logic sat);
            return clip((v * DEG_PER_RAD + (64'sd1 <<< 23)) >>> 24, sat);
        endfunction

        function t_basis predict_basis(logic [31:0] sample);
            t_basis r;
            longint smp, x, y, z, dx, dy, c, s, r1, r2;
            longint unsigned mag, rem, per, prod, ms, mc, lim, q;
            logic [31:0] ph;
            logic [1:0] kind;
            logic sat, raw_ph;
            smp = longint'(signed'(sample));
            r1 = 0;
            r2 = 0;
            sat = 1'b0;
            raw_ph = 1'b0;
            per = period;
            ph = '0;
            case (mode)
                ppb_pkg::MODE_SIN:    kind = ppb_pkg::KIND_SIN;
                ppb_pkg::MODE_COS:    kind = ppb_pkg::KIND_COS;
                ppb_pkg::MODE_DAY: begin
                    kind = ppb_pkg::KIND_COS;
                    per = ppb_pkg::DAY_PERIOD;
                end
                ppb_pkg::MODE_YEAR: begin
                    kind = ppb_pkg::KIND_COS;
                    per = ppb_pkg::YEAR_PERIOD;
                end
                ppb_pkg::MODE_TAN: begin
                    kind = ppb_pkg::KIND_TAN;
                    raw_ph = 1'b1;
                end
                ppb_pkg::MODE_SINCOS: kind = ppb_pkg::KIND_SINCOS;
                default: begin
                    kind = ppb_pkg::KIND_COS;
                    raw_ph = 1'b1;
                end
            endcase
            if (!raw_ph && per == 0) begin
                r.first_res = '0;
                r.second_res = '0;
                r.sat = 1'b1;
                return r;
            end
            if (raw_ph) begin
                prod = longint'(smp) * TURNS_PER_RAD;
                ph = prod[47:16];
            end else begin
                mag = (smp < 0) ? -smp : smp;
                rem = mag % per;
                if (smp < 0 && rem != 0) rem = per - rem;
                prod = (rem << 32) / per;
                ph = prod[31:0];
                prod = longint'(signed'(offset)) * TURNS_PER_RAD;
                ph = ph + prod[59:28];
            end
            x = ROT_GAIN;
            y = 0;
            z = {34'd0, ph[29:0]};
            for (int i = 0; i < STAGES; i++) begin
                dx = y >>> (i & 31);
                dy = x >>> (i & 31);
                if (z >= 0) begin
                    x = x - dx; y = y + dy; z = z - ARC_TURNS[i & 31];
                end else begin
                    x = x + dx; y = y - dy; z = z + ARC_TURNS[i & 31];
                end
            end
            case (ph[31:30])
                2'd0: begin c = x;  s = y;  end
                2'd1: begin c = -y; s = x;  end
                2'd2: begin c = -x; s = -y; end
                default: begin c = y; s = -x; end
            endcase
            case (kind)
                ppb_pkg::KIND_SIN: r1 = q24(s);
                ppb_pkg::KIND_COS: r1 = q24(c);
                ppb_pkg::KIND_TAN: begin
                    ms = (s < 0) ? -s : s;
                    mc = (c < 0) ? -c : c;
                    lim = ((s < 0) != (c < 0)) ? 64'd2147483648 : 64'd2147483647;
                    if (mc == 0) begin
                        sat = 1'b1;
                        r1 = (s < 0) ? -64'sd2147483648 : 64'sd2147483647;
                    end else begin
                        q = (ms << 24) / mc;
                        if (q > lim) begin
                            sat = 1'b1;
                            q = lim;
                        end
                        r1 = ((s < 0) != (c < 0)) ? -longint'(q) : longint'(q);
                    end
                end
                default: begin r1 = q24(s); r2 = q24(c); end
            endcase
            if (deg) begin
                r1 = degrees(r1, sat);
                r2 = degrees(r2, sat);
            end
            r1 = clip(r1, sat);
            r2 = clip(r2, sat);
            r.first_res = r1[31:0];
            r.second_res = r2[31:0];
            r.sat = sat;
            return r;
        endfunction

        function void note_sample(logic [31:0] sample);
            pending.push_back(predict_basis(sample));
        endfunction

        function void check_result(logic [31:0] first_res, logic [31:0] second_res,
                                   logic sat);
            t_basis e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h %h %b", first_res, second_res, sat);
                return;
            end
            e = pending.pop_front();
            if (e.first_res !== first_res || e.second_res !== second_res
                    || e.sat !== sat) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %h %h %b, got %h %h %b",
                             e.first_res, e.second_res, e.sat,
                             first_res, second_res, sat);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [31:0] i_s_tdata;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [63:0] o_m_tdata;
    logic        o_m_tuser;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    t_basis_scoreboard sb;
    int  cycles;
    int  results_seen;
    bit  no_gaps;
    bit  held_off;

    periodic_phase_basis_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.check_result(o_m_tdata[31:0], o_m_tdata[63:32], o_m_tuser);
            results_seen <= results_seen + 1;
        end
    end

    // Drain side: random stalls, one long hold-off to back up the pipeline.
    initial begin
        int w;
        i_m_tready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!held_off && results_seen >= HOLD_AFTER) begin
                held_off = 1'b1;
                i_m_tready <= 1'b0;
                repeat (700) @(posedge i_clk);
            end
            w = no_gaps ? 0 : $urandom_range(0, 19);
            if (w > 0) begin
                i_m_tready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    task automatic write_reg(logic [7:0] idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, val);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_sample(logic [31:0] sample);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= sample;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_sample(sample);
    endtask

    task automatic drain;
        i_s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_sample();
        case ($urandom_range(0, 5))
            0, 1: return $urandom;
            2: return $urandom_range(0, 32'h0003FFFF) - 32'h00020000;
            3: return sb.period * $urandom_range(0, 40) + $urandom_range(0, 3) - 1;
            4: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            default: return 32'd102944 + $urandom_range(0, 8) - 4;
        endcase
    endfunction

    initial begin
        logic [31:0] edge_samples [$];
        sb = new();
        no_gaps = 1'b0;
        i_rst_n <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        edge_samples = '{32'h0, 32'h1, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                         32'h00180000, 32'hFFE80000, 32'h000C0000, 32'h00060000,
                         32'h00120000, 32'd102944, 32'd205887, 32'd308831,
                         32'd411775, 32'hFFFE6DE0, 32'hAAAAAAAA, 32'h55555555};
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: ;
                1: begin
                    write_reg(ppb_pkg::REG_MODE, ppb_pkg::MODE_COS);
                    write_reg(ppb_pkg::REG_PERIOD, 32'd1);
                    write_reg(ppb_pkg::REG_OFFSET, 32'h7FFFFFFF);
                    write_reg(ppb_pkg::REG_SCALE, 32'd1);
                end
                2: begin
                    write_reg(ppb_pkg::REG_MODE, ppb_pkg::MODE_DAY);
                    write_reg(ppb_pkg::REG_OFFSET, 32'h80000000);
                    write_reg(ppb_pkg::REG_SCALE, 32'd0);
                end
                3: begin
                    write_reg(ppb_pkg::REG_MODE, ppb_pkg::MODE_YEAR);
                    write_reg(ppb_pkg::REG_SCALE, 32'd1);
                    write_reg(8'd4, $urandom);
                end
                4: write_reg(ppb_pkg::REG_MODE, ppb_pkg::MODE_TAN);
                5: write_reg(ppb_pkg::REG_SCALE, 32'd0);
                6: begin
                    write_reg(ppb_pkg::REG_MODE, ppb_pkg::MODE_SINCOS);
                    write_reg(ppb_pkg::REG_PERIOD, 32'hFFFFFFFF);
                    write_reg(ppb_pkg::REG_OFFSET, $urandom);
                end
                7: write_reg(ppb_pkg::REG_PERIOD, 32'd0);
                8: begin
                    write_reg(ppb_pkg::REG_MODE, ppb_pkg::MODE_RAW_COS);
                    write_reg(ppb_pkg::REG_SCALE, 32'd1);
                end
                9: write_reg(ppb_pkg::REG_MODE, 32'd7);
                10: begin
                    write_reg(ppb_pkg::REG_MODE, ppb_pkg::MODE_SIN);
                    write_reg(ppb_pkg::REG_PERIOD, 32'd0);
                end
                default: begin
                    write_reg(ppb_pkg::REG_MODE, $urandom_range(0, 7));
                    write_reg(ppb_pkg::REG_PERIOD, $urandom_range(0, 3) == 0 ?
                              $urandom : $urandom_range(1, 32'h00400000));
                    write_reg(ppb_pkg::REG_OFFSET, $urandom);
                    write_reg(ppb_pkg::REG_SCALE, $urandom_range(0, 1));
                end
            endcase
            no_gaps = (ph % 3 == 2);
            foreach (edge_samples[k]) send_sample(edge_samples[k]);
            for (int n = 0; n < PER_PHASE - edge_samples.size(); n++)
                send_sample(pick_sample());
            drain();
        end

        if (sb.mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### filelist.f
sv/ppb_pkg.sv
sv/ppb_div_cell.sv
sv/ppb_cordic_cell.sv
sv/periodic_phase_basis_top.sv
sim/periodic_phase_basis_top_tb.sv
